FILE: rtl/assert_macros.svh
// assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/fsfla_pkg.sv
`timescale 1ns / 1ps
package fsfla_pkg;

	localparam int SLOTS_PER_BLOCK = 512;
	localparam int NUM_BLOCKS      = 8;
	localparam int TOTAL_SLOTS     = SLOTS_PER_BLOCK * NUM_BLOCKS;
	localparam int IDX_W           = $clog2(TOTAL_SLOTS);
	localparam int OFF_W           = $clog2(SLOTS_PER_BLOCK);
	localparam int BLK_W           = $clog2(NUM_BLOCKS + 1);
	localparam int SLOT_W          = 12;
	localparam int STATUS_W        = 2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC     = 2'd0,
		ST_FREED     = 2'd1,
		ST_IGNORED   = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot_index;
		logic              is_null;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef struct packed {
		logic take;   // request accepted this cycle
		logic read;   // accepted allocate that pops the linked list
		logic pop;    // link data back, advance head
		logic drain;  // response taken downstream
	} cmd_t;

	typedef struct packed {
		logic head_vld;
		logic rsp_busy;
	} stat_t;

endpackage

FILE: rtl/fsfla_ctrl.sv
`timescale 1ns / 1ps
module fsfla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_func,
	input  logic               rsp_stall,
	input  fsfla_pkg::stat_t   stat,
	output logic               req_stall,
	output fsfla_pkg::cmd_t    cmd
);
	import fsfla_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_nxt;
	logic   rsp_free;

	assign rsp_free  = !stat.rsp_busy || !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) && rsp_free);

	always_comb begin
		cmd.take  = req_valid && !req_stall;
		cmd.read  = cmd.take && (req_func == FUNC_ALLOC) && stat.head_vld;
		cmd.pop   = (state_q == S_READ);
		cmd.drain = stat.rsp_busy && !rsp_stall;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (cmd.read) state_nxt = S_READ;
			S_READ: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

endmodule

FILE: rtl/fsfla_dpath.sv
`timescale 1ns / 1ps
module fsfla_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  fsfla_pkg::cmd_t  cmd,
	input  fsfla_pkg::req_t  req,
	output fsfla_pkg::stat_t stat,
	output logic             rsp_valid,
	output fsfla_pkg::rsp_t  rsp
);
	import fsfla_pkg::*;

	link_t            link_mem [TOTAL_SLOTS];
	link_t            rdata_q;

	logic [IDX_W-1:0] head_q;
	logic             head_vld_q;
	logic [IDX_W-1:0] fresh_q;
	logic             fresh_vld_q;
	logic [OFF_W-1:0] off_q;
	logic [BLK_W-1:0] blocks_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             fast;
	logic             is_free;
	logic             ignore;
	logic             wr_en;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] claim_idx;
	logic             pool_full;
	logic             fresh_last;
	logic             do_fresh;
	logic             do_claim;
	rsp_t             rsp_nxt;

	assign fast       = cmd.take && !cmd.read;
	assign is_free    = (req.func == FUNC_FREE);
	assign ignore     = req.is_null || (32'(req.slot_index) >= TOTAL_SLOTS);
	assign free_idx   = IDX_W'(req.slot_index);
	assign wr_en      = fast && is_free && !ignore;
	assign claim_idx  = IDX_W'(32'(blocks_q) * SLOTS_PER_BLOCK);
	assign pool_full  = (blocks_q >= BLK_W'(NUM_BLOCKS));
	assign fresh_last = (off_q == OFF_W'(SLOTS_PER_BLOCK - 1));
	assign do_fresh   = fast && !is_free && fresh_vld_q;
	assign do_claim   = fast && !is_free && !fresh_vld_q && !pool_full;

	always_comb begin
		rsp_nxt = '0;
		priority if (cmd.pop) begin
			rsp_nxt.granted_slot = SLOT_W'(head_q);
			rsp_nxt.status       = ST_ALLOC;
		end else if (is_free) begin
			rsp_nxt.status = ignore ? ST_IGNORED : ST_FREED;
		end else if (fresh_vld_q) begin
			rsp_nxt.granted_slot = SLOT_W'(fresh_q);
			rsp_nxt.status       = ST_ALLOC;
		end else if (pool_full) begin
			rsp_nxt.status = ST_EXHAUSTED;
		end else begin
			rsp_nxt.granted_slot = SLOT_W'(claim_idx);
			rsp_nxt.status       = ST_ALLOC;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) link_mem[free_idx] <= '{vld: head_vld_q, idx: head_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.read) rdata_q <= link_mem[head_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= 1'b0;
			fresh_vld_q <= 1'b0;
			blocks_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) head_vld_q <= rdata_q.vld;
			else if (wr_en) head_vld_q <= 1'b1;
			if (do_fresh && fresh_last) fresh_vld_q <= 1'b0;
			else if (do_claim) fresh_vld_q <= 1'b1;
			if (do_claim) blocks_q <= blocks_q + 1'b1;
			if (fast || cmd.pop) rsp_valid_q <= 1'b1;
			else if (cmd.drain) rsp_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.pop) head_q <= rdata_q.idx;
		else if (wr_en) head_q <= free_idx;
		if (do_fresh) begin
			fresh_q <= fresh_q + 1'b1;
			off_q   <= off_q + 1'b1;
		end else if (do_claim) begin
			fresh_q <= claim_idx + 1'b1;
			off_q   <= OFF_W'(1);
		end
		if (fast || cmd.pop) rsp_q <= rsp_nxt;
	end

	assign stat.head_vld = head_vld_q;
	assign stat.rsp_busy = rsp_valid_q;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

FILE: rtl/fixed_slot_free_list_allocator.sv
// Response: a free, an ignored free, a fresh-block allocate or an exhausted
//   allocate responds in the cycle after acceptance; a pop from the list
//   goes through the registered link-memory read, then the response register.
// Throughput: one request per cycle, held off by a stalled response or a pop.
// Reset (arst_n, async): free list empty, no fresh slots, no blocks claimed;
//   the link memory is not cleared and is only read where written.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fixed_slot_free_list_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fsfla_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fsfla_pkg::rsp_t rsp
);
	import fsfla_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fsfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	fsfla_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`ASSERT_IMPL(a_pop_rsp_free, clk, arst_n, cmd.pop, !rsp_valid)
	`ASSERT_NEXT(a_read_then_pop, clk, arst_n, cmd.read, cmd.pop)
	`ASSERT_IMPL(a_pop_blocks_req, clk, arst_n, cmd.pop, req_stall)
	`ASSERT_NEXT(a_take_gives_rsp, clk, arst_n, cmd.take && !cmd.read, rsp_valid)

endmodule

FILE: tb/sv/tb_fixed_slot_free_list_allocator.sv
`timescale 1ns / 1ps
module tb_fixed_slot_free_list_allocator;
	import fsfla_pkg::*;

	localparam logic [IDX_W:0] NIL_SLOT = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	fixed_slot_free_list_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the allocator state
	logic [IDX_W:0] mirror_head = NIL_SLOT;
	logic [IDX_W:0] mirror_link [0:TOTAL_SLOTS-1];
	logic [IDX_W:0] mirror_fresh = NIL_SLOT;
	int mirror_blocks = 0;

	req_t request_queue[$];
	rsp_t pending_responses[$];
	logic [SLOT_W-1:0] held_slots[$];

	int mismatches = 0;
	int grants_seen = 0;
	int frees_seen = 0;
	int ignored_seen = 0;
	int exhausted_seen = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	rsp_t want;

	function automatic rsp_t compute_slot_response(input req_t r);
		rsp_t o;
		logic [IDX_W:0] s;
		o.granted_slot = '0;
		o.status = ST_IGNORED;
		if (r.func == FUNC_ALLOC) begin
			if (mirror_head != NIL_SLOT) begin
				o.granted_slot = mirror_head[SLOT_W-1:0];
				o.status = ST_ALLOC;
				mirror_head = mirror_link[mirror_head[IDX_W-1:0]];
			end else if (mirror_fresh != NIL_SLOT) begin
				o.granted_slot = mirror_fresh[SLOT_W-1:0];
				o.status = ST_ALLOC;
				if ((int'(mirror_fresh) + 1) % SLOTS_PER_BLOCK == 0)
					mirror_fresh = NIL_SLOT;
				else
					mirror_fresh = mirror_fresh + 1'b1;
			end else if (mirror_blocks >= NUM_BLOCKS) begin
				o.status = ST_EXHAUSTED;
			end else begin
				s = (IDX_W+1)'(mirror_blocks * SLOTS_PER_BLOCK);
				o.granted_slot = s[SLOT_W-1:0];
				o.status = ST_ALLOC;
				mirror_blocks++;
				mirror_fresh = s + 1'b1;
			end
		end else if (r.is_null || int'(r.slot_index) >= TOTAL_SLOTS) begin
			o.status = ST_IGNORED;
		end else begin
			mirror_link[r.slot_index] = mirror_head;
			mirror_head = {1'b0, r.slot_index};
			o.status = ST_FREED;
		end
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				pending_responses.push_back(compute_slot_response(req));
				if (!calm && $urandom_range(0, 99) < 10)
					send_gap = $urandom_range(1, 15);
			end
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				req <= request_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_responses.size() == 0) begin
					mismatches++;
					$display("%0t: response with none expected: slot %0d status %0d",
						$time, rsp.granted_slot, rsp.status);
				end else begin
					want = pending_responses.pop_front();
					if (rsp.granted_slot !== want.granted_slot) begin
						mismatches++;
						$display("%0t: granted_slot expected %0d actual %0d",
							$time, want.granted_slot, rsp.granted_slot);
					end
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
					case (status_t'(want.status))
						ST_ALLOC: begin
							grants_seen++;
							held_slots.push_back(want.granted_slot);
						end
						ST_FREED: frees_seen++;
						ST_IGNORED: ignored_seen++;
						ST_EXHAUSTED: exhausted_seen++;
						default: ;
					endcase
				end
			end
			if (hold_req) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(0, 14);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic queue_request(input logic f, input logic [SLOT_W-1:0] idx, input logic nul);
		req_t r;
		r.func = f;
		r.slot_index = idx;
		r.is_null = nul;
		while (request_queue.size() >= 4)
			@(negedge clk);
		request_queue.push_back(r);
	endtask

	task automatic wait_idle();
		while (request_queue.size() != 0 || req_valid || pending_responses.size() != 0)
			@(negedge clk);
	endtask

	task automatic release_held();
		int k;
		logic [SLOT_W-1:0] s;
		if (held_slots.size() == 0) begin
			queue_request(FUNC_FREE, SLOT_W'($urandom), 1'b0);
		end else begin
			k = $urandom_range(0, held_slots.size() - 1);
			s = held_slots[k];
			held_slots.delete(k);
			queue_request(FUNC_FREE, s, 1'b0);
		end
	endtask

	// allocates at alloc_pct, else mostly frees of granted slots; some foreign or double frees and null frees
	task automatic mixed_traffic(input int n, input int alloc_pct);
		int r;
		repeat (n) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				queue_request(FUNC_ALLOC, SLOT_W'($urandom), 1'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					release_held();
				else if (r < 88)
					queue_request(FUNC_FREE, SLOT_W'($urandom), 1'b0);
				else
					queue_request(FUNC_FREE, SLOT_W'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fresh block, null frees, foreign and double free, ignored fields
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'hFFF, 1'b0);
		queue_request(FUNC_FREE, 12'd0, 1'b0);
		queue_request(FUNC_FREE, 12'hFFF, 1'b1);
		queue_request(FUNC_FREE, 12'd0, 1'b1);
		queue_request(FUNC_FREE, 12'hFFF, 1'b0);
		queue_request(FUNC_FREE, 12'hFFF, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'hFFF, 1'b1);
		queue_request(FUNC_FREE, 12'd2, 1'b0);
		queue_request(FUNC_FREE, 12'd3, 1'b0);
		queue_request(FUNC_FREE, 12'd1, 1'b0);
		queue_request(FUNC_ALLOC, 12'h555, 1'b1);
		queue_request(FUNC_ALLOC, 12'hAAA, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_ALLOC, 12'd0, 1'b0);
		queue_request(FUNC_FREE, 12'hAAA, 1'b1);
		wait_idle();

		// long receiver hold-off while requests keep coming
		hold_req = 1'b1;
		mixed_traffic(150, 55);
		mixed_traffic(300, 80);
		mixed_traffic(200, 35);
		mixed_traffic(200, 65);
		wait_idle();

		// return a batch of held slots, then allocate heavily
		repeat (40) release_held();
		repeat (60) queue_request(FUNC_ALLOC, SLOT_W'($urandom), 1'($urandom));
		mixed_traffic(100, 50);
		wait_idle();

		calm = 1'b1;
		mixed_traffic(80, 50);
		wait_idle();
		repeat (20) @(negedge clk);

		$display("Checked %0d grants, %0d frees, %0d ignored frees, %0d exhausted allocates",
			grants_seen, frees_seen, ignored_seen, exhausted_seen);
		$display("Blocks claimed: %0d of %0d", mirror_blocks, NUM_BLOCKS);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout waiting for responses");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
